@@ hw/rtl/salc_pkg.sv @@
// ----------------------------------------------------------------------------
// salc_pkg: shared types and constants of the cache tag controller
// Request and response payloads, command and status groups between the
// controller and the datapath, and default geometry.
// ----------------------------------------------------------------------------
package salc_pkg;

  localparam int ADDR_W      = 64;
  localparam int VTAG_W      = 51;
  localparam int CNT_W       = 32;
  localparam int HPOS_W      = 2;

  localparam int DEF_WAYS        = 4;
  localparam int DEF_SETS        = 128;
  localparam int DEF_OFFSET_BITS = 6;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef struct packed {
    logic              command;
    logic [ADDR_W-1:0] address;
  } salc_req_t;

  typedef struct packed {
    logic              hit;
    logic [HPOS_W-1:0] hit_position;
    logic              hit_was_dirty;
    logic              victim_valid;
    logic              writeback;
    logic [VTAG_W-1:0] victim_tag;
    logic [CNT_W-1:0]  access_count;
    logic [CNT_W-1:0]  miss_count;
    logic [CNT_W-1:0]  writeback_count;
  } salc_rsp_t;

  typedef struct packed {
    logic clear_en;
    logic load;
    logic commit;
  } salc_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_blocked;
  } salc_status_t;

endpackage

@@ hw/rtl/salc_ctrl.sv @@
// ----------------------------------------------------------------------------
// salc_ctrl: sequencing of the cache tag controller
// Runs the state clearing pass after reset, then takes one request at a time
// through a set read and a set update.
// ----------------------------------------------------------------------------
module salc_ctrl
  import salc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  salc_status_t status_i,
  output salc_cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_en = 1'b1;
        if (status_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (!status_i.out_blocked) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hw/rtl/salc_datapath.sv @@
// ----------------------------------------------------------------------------
// salc_datapath: set memories, lookup, LRU update and counters
// Each set is one row holding its lines in LRU order, most recent first.
// ----------------------------------------------------------------------------
module salc_datapath
  import salc_pkg::*;
#(
  parameter int WAYS        = DEF_WAYS,
  parameter int SETS        = DEF_SETS,
  parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  salc_cmd_t    cmd_i,
  output salc_status_t status_o,
  input  salc_req_t    in_req_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output salc_rsp_t    out_rsp_o
);

  localparam int SET_BITS = $clog2(SETS + 1) - 1;
  localparam int ROWS     = 1 << SET_BITS;
  localparam int TAG_W    = ADDR_W - OFFSET_BITS - SET_BITS;
  localparam int POS_W    = $clog2(WAYS);
  localparam int TAG_LSB  = OFFSET_BITS + SET_BITS;

  logic [WAYS-1:0][TAG_W-1:0] tag_mem [ROWS];
  logic [2*WAYS-1:0]          st_mem  [ROWS];

  logic [SET_BITS-1:0]        clr_q;
  salc_req_t                  req_q;
  logic [WAYS-1:0][TAG_W-1:0] rd_tag_q;
  logic [2*WAYS-1:0]          rd_st_q;
  logic [CNT_W-1:0]           acc_q, miss_q, wb_q;
  logic [CNT_W-1:0]           acc_d, miss_d, wb_d;
  logic                       out_valid_q;
  salc_rsp_t                  out_q, rsp_d;

  logic [SET_BITS-1:0]        in_set, cur_set, wr_addr;
  logic [TAG_W-1:0]           cur_tag;
  logic [WAYS-1:0]            old_vld, old_drt, new_vld, new_drt;
  logic [WAYS-1:0][TAG_W-1:0] new_tag;
  logic                       hit;
  logic [POS_W-1:0]           pos, sh;
  logic                       is_write;
  logic                       st_we;
  logic [2*WAYS-1:0]          st_wdata;

  assign in_set   = in_req_i.address[TAG_LSB-1:OFFSET_BITS];
  assign cur_set  = req_q.address[TAG_LSB-1:OFFSET_BITS];
  assign cur_tag  = req_q.address[ADDR_W-1:TAG_LSB];
  assign is_write = (req_q.command == CMD_WRITE);
  assign old_vld  = rd_st_q[WAYS-1:0];
  assign old_drt  = rd_st_q[2*WAYS-1:WAYS];

  always_comb begin
    hit = 1'b0;
    pos = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit && old_vld[w] && (rd_tag_q[w] == cur_tag)) begin
        hit = 1'b1;
        pos = POS_W'(w);
      end
    end
  end

  assign sh = hit ? pos : POS_W'(WAYS - 1);

  always_comb begin
    new_tag    = rd_tag_q;
    new_vld    = old_vld;
    new_drt    = old_drt;
    new_tag[0] = cur_tag;
    new_vld[0] = 1'b1;
    new_drt[0] = hit ? (old_drt[pos] | is_write) : is_write;
    for (int w = 1; w < WAYS; w++) begin
      if (w <= int'(sh)) begin
        new_tag[w] = rd_tag_q[w-1];
        new_vld[w] = old_vld[w-1];
        new_drt[w] = old_drt[w-1];
      end
    end
  end

  always_comb begin
    acc_d  = (acc_q == '1) ? acc_q : acc_q + 1'b1;
    miss_d = miss_q;
    wb_d   = wb_q;
    rsp_d  = '0;
    if (hit) begin
      rsp_d.hit           = 1'b1;
      rsp_d.hit_position  = HPOS_W'(pos);
      rsp_d.hit_was_dirty = old_drt[pos];
    end else begin
      miss_d = (miss_q == '1) ? miss_q : miss_q + 1'b1;
      if (old_vld[WAYS-1]) begin
        rsp_d.victim_valid = 1'b1;
        rsp_d.victim_tag   = VTAG_W'(rd_tag_q[WAYS-1]);
        if (old_drt[WAYS-1]) begin
          rsp_d.writeback = 1'b1;
          wb_d            = (wb_q == '1) ? wb_q : wb_q + 1'b1;
        end
      end
    end
    rsp_d.access_count    = acc_d;
    rsp_d.miss_count      = miss_d;
    rsp_d.writeback_count = wb_d;
  end

  assign st_we    = cmd_i.clear_en | cmd_i.commit;
  assign wr_addr  = cmd_i.clear_en ? clr_q : cur_set;
  assign st_wdata = cmd_i.clear_en ? '0 : {new_drt, new_vld};

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      st_mem[wr_addr] <= st_wdata;
    end
    if (cmd_i.commit) begin
      tag_mem[cur_set] <= new_tag;
    end
    if (cmd_i.load) begin
      req_q    <= in_req_i;
      rd_tag_q <= tag_mem[in_set];
      rd_st_q  <= st_mem[in_set];
    end
    if (cmd_i.commit) begin
      out_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      acc_q       <= '0;
      miss_q      <= '0;
      wb_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear_en) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.commit) begin
        acc_q       <= acc_d;
        miss_q      <= miss_d;
        wb_q        <= wb_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.clear_last  = (clr_q == '1);
  assign status_o.out_blocked = out_valid_q & out_stall_i;
  assign out_valid_o          = out_valid_q;
  assign out_rsp_o            = out_q;

endmodule

@@ hw/rtl/set_assoc_lru_cache_tags.sv @@
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tags: write-back set-associative cache tag controller
// True LRU replacement, one response per request with outcome and counters.
// ----------------------------------------------------------------------------
// Each request first reads its set row from the tag and state memories,
// then compares all ways, updates the LRU order and writes the row back;
// the write-back step waits while an untaken response is held in the
// response register, and a new request is accepted only after it. After
// reset the line state memory is cleared one set per cycle, all
// 2**floor(log2(SETS)) set rows, before the first request is accepted.
module set_assoc_lru_cache_tags
  import salc_pkg::*;
#(
  parameter int WAYS        = DEF_WAYS,
  parameter int SETS        = DEF_SETS,
  parameter int OFFSET_BITS = DEF_OFFSET_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  salc_req_t in_req_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output salc_rsp_t out_rsp_o
);

  salc_cmd_t    cmd;
  salc_status_t status;

  salc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  salc_datapath #(
    .WAYS        (WAYS),
    .SETS        (SETS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule
